>>> sv/tcw_pkg.sv
// tcw_pkg: shared types and constants for the text console writer
// no dependencies; imported by every module of the block except tcw_ram
`timescale 1ns / 1ps

package tcw_pkg;

    // default geometry of the screen
    localparam int SCREEN_ROWS_DEF = 25;
    localparam int MAX_COLUMNS_DEF = 128;

    // character and attribute constants
    localparam logic [7:0] NEWLINE_CODE     = 8'd10;
    localparam logic [7:0] BLANK_ATTR       = 8'd7;
    localparam logic [7:0] COLUMN_COUNT_RST = 8'd80;

    // operation codes of an input word
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } in_item_t;

    typedef struct packed {
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic take_item;
        logic start_sweep;
        logic load_out;
    } tcw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_scroll;
        logic sweep_done;
    } tcw_sts_t;

endpackage

>>> sv/tcw_ram.sv
// tcw_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/tcw_datapath.sv
// tcw_datapath: cursor registers, screen rams, copy/clear sweep and result register
// depends on tcw_pkg and tcw_ram
`timescale 1ns / 1ps

module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [7:0] cfg_data,
    input  in_item_t  s_item,
    input  tcw_cmd_t  cmd,
    output tcw_sts_t  sts,
    output out_item_t m_item
);

    localparam int ROW_W      = $clog2(SCREEN_ROWS);
    localparam int COL_W      = $clog2(MAX_COLUMNS);
    localparam int CNT_W      = COL_W + 1;
    localparam int ROW_STRIDE = 1 << COL_W;
    localparam int DEPTH      = SCREEN_ROWS * ROW_STRIDE;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int COPY_LEN   = (SCREEN_ROWS - 1) * ROW_STRIDE;

    function automatic logic [CNT_W-1:0] clamp_cols(input logic [7:0] cc);
        logic [CNT_W-1:0] res;
        if (cc == 8'd0) begin
            res = CNT_W'(1);
        end else if (32'(cc) > 32'(MAX_COLUMNS)) begin
            res = CNT_W'(MAX_COLUMNS);
        end else begin
            res = CNT_W'(cc);
        end
        return res;
    endfunction

    logic [CNT_W-1:0]  eff_cols_reg, eff_cols_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic              scrolled_reg, scrolled_next;
    logic              rd_flag_reg, rd_flag_next;
    logic              sweep_on_reg, sweep_on_next;
    logic              clear_reg, clear_next;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic              wr_on_reg, wr_on_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic              wr_copy_reg, wr_copy_next;
    out_item_t         m_item_reg, m_item_next;

    logic              is_read, is_nl, in_range, wrap, row_step, put_scroll, put_we;
    logic [CNT_W-1:0]  col_inc;
    logic [ROW_W:0]    row_inc;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  put_row;
    logic              in_copy, ptr_last;

    logic              char_we, attr_we, ram_re;
    logic [ADDR_W-1:0] char_waddr, ram_raddr;
    logic [7:0]        char_wdata, attr_wdata, char_rdata, attr_rdata;

    // cursor advance for a put word
    always_comb begin
        is_read    = (s_item.operation == OP_READ);
        is_nl      = (s_item.char_code == NEWLINE_CODE);
        in_range   = (32'(s_item.read_row) < 32'(SCREEN_ROWS))
                  && (32'(s_item.read_col) < 32'(MAX_COLUMNS));
        col_inc    = {1'b0, col_reg} + CNT_W'(1);
        wrap       = (col_inc >= eff_cols_reg);
        row_step   = is_nl || wrap;
        row_inc    = {1'b0, row_reg} + (ROW_W+1)'(1);
        put_scroll = row_step && (row_inc >= (ROW_W+1)'(SCREEN_ROWS));
        put_col    = row_step ? '0 : col_inc[COL_W-1:0];
        if (!row_step) begin
            put_row = row_reg;
        end else if (put_scroll) begin
            put_row = ROW_W'(SCREEN_ROWS - 1);
        end else begin
            put_row = row_inc[ROW_W-1:0];
        end
        put_we = cmd.take_item && !is_read && !is_nl;
    end

    assign sts.item_scroll = !is_read && put_scroll;

    // sweep over the whole screen: copy one row up, then blank (or clear all)
    always_comb begin
        ptr_last = (ptr_reg == ADDR_W'(DEPTH - 1));
        in_copy  = !clear_reg && (ptr_reg < ADDR_W'(COPY_LEN));
    end

    assign sts.sweep_done = wr_on_reg && (wr_addr_reg == ADDR_W'(DEPTH - 1));

    always_comb begin
        eff_cols_next = cfg_we ? clamp_cols(cfg_data) : eff_cols_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        scrolled_next = scrolled_reg;
        rd_flag_next  = rd_flag_reg;
        if (cmd.take_item) begin
            scrolled_next = !is_read && put_scroll;
            rd_flag_next  = is_read && in_range;
            if (!is_read) begin
                col_next = put_col;
                row_next = put_row;
            end
        end

        sweep_on_next = sweep_on_reg;
        clear_next    = clear_reg;
        ptr_next      = ptr_reg;
        if (cmd.start_sweep) begin
            sweep_on_next = 1'b1;
            clear_next    = 1'b0;
            ptr_next      = '0;
        end else if (sweep_on_reg) begin
            ptr_next = ptr_reg + ADDR_W'(1);
            if (ptr_last) begin
                sweep_on_next = 1'b0;
            end
        end
        wr_on_next   = sweep_on_reg;
        wr_addr_next = ptr_reg;
        wr_copy_next = in_copy;

        m_item_next = m_item_reg;
        if (cmd.load_out) begin
            m_item_next.cursor_col = 7'(col_reg);
            m_item_next.cursor_row = 5'(row_reg);
            m_item_next.scrolled   = scrolled_reg;
            m_item_next.cell_char  = rd_flag_reg ? char_rdata : 8'd0;
            m_item_next.cell_attr  = rd_flag_reg ? attr_rdata : 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_cols_reg <= clamp_cols(COLUMN_COUNT_RST);
            col_reg      <= '0;
            row_reg      <= '0;
            scrolled_reg <= 1'b0;
            rd_flag_reg  <= 1'b0;
            sweep_on_reg <= 1'b1;
            clear_reg    <= 1'b1;
            ptr_reg      <= '0;
            wr_on_reg    <= 1'b0;
        end else begin
            eff_cols_reg <= eff_cols_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            scrolled_reg <= scrolled_next;
            rd_flag_reg  <= rd_flag_next;
            sweep_on_reg <= sweep_on_next;
            clear_reg    <= clear_next;
            ptr_reg      <= ptr_next;
            wr_on_reg    <= wr_on_next;
        end
        wr_addr_reg <= wr_addr_next;
        wr_copy_reg <= wr_copy_next;
        m_item_reg  <= m_item_next;
    end

    // ram port selection
    always_comb begin
        char_we    = wr_on_reg || put_we;
        char_waddr = wr_on_reg ? wr_addr_reg : {row_reg, col_reg};
        if (wr_on_reg) begin
            char_wdata = wr_copy_reg ? char_rdata : 8'd0;
        end else begin
            char_wdata = s_item.char_code;
        end
        attr_we = wr_on_reg;
        if (wr_copy_reg) begin
            attr_wdata = attr_rdata;
        end else begin
            attr_wdata = clear_reg ? 8'd0 : BLANK_ATTR;
        end
        ram_re = (sweep_on_reg && in_copy) || (cmd.take_item && is_read && in_range);
        if (sweep_on_reg) begin
            ram_raddr = ptr_reg + ADDR_W'(ROW_STRIDE);
        end else begin
            ram_raddr = {ROW_W'(s_item.read_row), COL_W'(s_item.read_col)};
        end
    end

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_char_ram (
        .aclk  (aclk),
        .we    (char_we),
        .waddr (char_waddr),
        .wdata (char_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (char_rdata)
    );

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_attr_ram (
        .aclk  (aclk),
        .we    (attr_we),
        .waddr (wr_addr_reg),
        .wdata (attr_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (attr_rdata)
    );

    assign m_item = m_item_reg;

endmodule

>>> sv/tcw_ctrl.sv
// tcw_ctrl: control state machine and output valid flag
// depends on tcw_pkg
`timescale 1ns / 1ps

module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  tcw_sts_t sts,
    output tcw_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_FIN    = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.take_item = 1'b1;
                    if (sts.item_scroll) begin
                        cmd.start_sweep = 1'b1;
                        state_next      = ST_SCROLL;
                    end else begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SCROLL: begin
                if (sts.sweep_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase

        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> sv/text_console_writer_core.sv
// text_console_writer_core: top level of the text console writer
// depends on tcw_pkg, tcw_ctrl, tcw_datapath, tcw_ram
`timescale 1ns / 1ps

// text console writer: a screen of SCREEN_ROWS rows by MAX_COLUMNS cells,
// each cell a character byte and an attribute byte
//
// channels
//   cfg_*  write-only column count register, always ready, write it while idle
//   s_*    input words: put a character (newline moves to the next row) or
//          read one cell
//   m_*    one result word per input word: cursor, scroll flag, read cell
//
// word sequence
//   put or read without scroll: accept, then result load, then the next word
//   put that scrolls: accept, a sweep over SCREEN_ROWS * 2**clog2(MAX_COLUMNS)
//   cells, then result load; the single write port of the screen rams
//   moves one cell per cycle during the row copy and bottom-row blanking
//
// reset: the cursor goes home and a clearing pass zeroes every cell,
// one cell per cycle; s_ready stays low while it runs
//
// stall: a finished word waits in the output register; the next input word
// is still accepted, and its result waits until the register is taken

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF,
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,

    // column count register
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,

    // input words
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,

    // result words
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    tcw_cmd_t cmd;
    tcw_sts_t sts;
    logic     cfg_we;

    // register writes must only happen while idle (the user's duty, not enforced here); the port never pushes back
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // sequencing: clear pass, accept, scroll sweep, result load
    tcw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // cursor, screen memories and result register
    tcw_datapath #(
        .SCREEN_ROWS (SCREEN_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_item   (s_item),
        .cmd      (cmd),
        .sts      (sts),
        .m_item   (m_item)
    );

endmodule

>>> sv/tcw_checker.sv
// tcw_checker: port-level assertions for text_console_writer_core, with its bind
// depends on tcw_pkg and text_console_writer_core
`timescale 1ns / 1ps

module tcw_checker
    import tcw_pkg::*;
#(
    parameter int SCREEN_ROWS = SCREEN_ROWS_DEF
) (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // a reset cycle starts the clearing pass: nothing accepted or shown next
    assert property (@(posedge aclk) !aresetn |=> !s_ready && !m_valid)
        else $error("tcw: block not quiet after reset");

    // a stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("tcw: stalled result word changed");

    // a scroll always leaves the cursor on the bottom row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.scrolled |-> m_item.cursor_row == 5'(SCREEN_ROWS - 1))
        else $error("tcw: scroll without cursor on bottom row");

    // cell contents only come with a read, which never scrolls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_item.cell_char != 8'd0) || (m_item.cell_attr != 8'd0))
        |-> !m_item.scrolled)
        else $error("tcw: cell data on a scrolling word");

endmodule

bind text_console_writer_core tcw_checker #(
    .SCREEN_ROWS (SCREEN_ROWS)
) u_tcw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
